// ===== rtl/core/aclc_pkg.sv =====
// Shared types, character codes and command table for the ASCII command LED controller.
package aclc_pkg;

   localparam int unsigned LINE_DEPTH_DEF = 16;

   // Longest command text; line bytes past this never take part in a match
   localparam int unsigned MATCH_LEN   = 8;
   localparam int unsigned MATCH_IDX_W = $clog2(MATCH_LEN);
   localparam int unsigned CMD_COUNT   = 7;

   localparam logic       MODE_CHAR = 1'b0;
   localparam logic       MODE_TICK = 1'b1;
   localparam logic [7:0] CHAR_NUL  = 8'h00;
   localparam logic [7:0] CHAR_CR   = 8'h0d;
   localparam logic [7:0] CHAR_BS   = 8'h7f;

   typedef enum logic [2:0] {
      CMD_RON      = 3'd0,
      CMD_ROFF     = 3'd1,
      CMD_GON      = 3'd2,
      CMD_GOFF     = 3'd3,
      CMD_RFLASH   = 3'd4,
      CMD_GFLASH   = 3'd5,
      CMD_FLASHOFF = 3'd6,
      CMD_NONE     = 3'd7
   } cmd_type;

   localparam logic [7:0] CMD_TEXT [CMD_COUNT][MATCH_LEN] = '{
      '{"R", "O", "N", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"R", "O", "F", "F",   8'h00, 8'h00, 8'h00, 8'h00},
      '{"G", "O", "N", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"G", "O", "F", "F",   8'h00, 8'h00, 8'h00, 8'h00},
      '{"R", "F", "L", "A",   "S",   "H",   8'h00, 8'h00},
      '{"G", "F", "L", "A",   "S",   "H",   8'h00, 8'h00},
      '{"F", "L", "A", "S",   "H",   "O",   "F",   "F"  }
   };

   localparam int unsigned CMD_LEN [CMD_COUNT] = '{3, 4, 3, 4, 6, 6, 8};

   typedef struct packed {
      logic    hit;
      cmd_type cmd;
   } match_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] rx_char;
   } req_type;

   typedef struct packed {
      logic       echo_valid;
      logic [7:0] echo_char;
      logic       red_led;
      logic       green_led;
      logic       red_flashing;
      logic       green_flashing;
      logic       command_done;
      logic       command_invalid;
   } rsp_type;

endpackage

// ===== rtl/core/aclc_if.sv =====
// Valid/ready channel interfaces for the request and response items.
interface aclc_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] rx_char;

   modport source (output valid, output mode, output rx_char, input ready);
   modport sink   (input valid, input mode, input rx_char, output ready);
endinterface

interface aclc_rsp_if;
   logic       valid;
   logic       ready;
   logic       echo_valid;
   logic [7:0] echo_char;
   logic       red_led;
   logic       green_led;
   logic       red_flashing;
   logic       green_flashing;
   logic       command_done;
   logic       command_invalid;

   modport source (output valid, output echo_valid, output echo_char, output red_led,
                   output green_led, output red_flashing, output green_flashing,
                   output command_done, output command_invalid, input ready);
   modport sink   (input valid, input echo_valid, input echo_char, input red_led,
                   input green_led, input red_flashing, input green_flashing,
                   input command_done, input command_invalid, output ready);
endinterface

// ===== rtl/core/aclc_matcher.sv =====
// Parallel exact compare of the stored line against the command table.
module aclc_matcher #(
   parameter int unsigned LINE_DEPTH = aclc_pkg::LINE_DEPTH_DEF,
   localparam int unsigned FILL_W    = $clog2(LINE_DEPTH + 1)
) (
   input  logic [7:0]          line_i [aclc_pkg::MATCH_LEN],
   input  logic [FILL_W-1:0]   fill_i,
   output aclc_pkg::match_type match_o
);

   logic [aclc_pkg::CMD_COUNT-1:0] hit_vec;

   // Only bytes below the command length are compared, so unwritten entries never matter
   always_comb begin
      for (int k = 0; k < aclc_pkg::CMD_COUNT; k++) begin
         hit_vec[k] = (fill_i == FILL_W'(aclc_pkg::CMD_LEN[k]));
         for (int i = 0; i < aclc_pkg::MATCH_LEN; i++) begin
            if (i < aclc_pkg::CMD_LEN[k] && line_i[i] != aclc_pkg::CMD_TEXT[k][i]) begin
               hit_vec[k] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      match_o.hit = |hit_vec;
      match_o.cmd = aclc_pkg::CMD_NONE;
      for (int k = aclc_pkg::CMD_COUNT - 1; k >= 0; k--) begin
         if (hit_vec[k]) begin
            match_o.cmd = aclc_pkg::cmd_type'(3'(k));
         end
      end
   end

endmodule

// ===== rtl/core/ascii_command_led_controller.sv =====
// Top level: line buffer, command decode and LED / flash state for ASCII commands.
//
// Usage
//   req_ch carries one item per handshake: mode 0 is a received character in
//   rx_char, mode 1 is a one-second tick. rsp_ch returns exactly one item per
//   request item: the echo (if any), the LED and flash levels after the item,
//   and command done / invalid flags when a carriage return closed a line.
//   Characters collect into the line; backspace removes one, a zero byte is
//   ignored, characters past a full line are echoed but dropped.
// Timing
//   An accepted item is held in the input register, is decoded by the
//   single-pass logic and lands in the result register, which drives the
//   response. One item per cycle is sustained while rsp_ch.ready stays high;
//   the line compare is one level of parallel byte compares.
// Stall
//   When rsp_ch.ready is low a full result register holds, and the input register
//   still takes one more item; req_ch.ready drops only when both are full.
// Reset
//   Synchronous, active high: both registers empty, line empty, LEDs and
//   flash flags off. Line bytes are not cleared.
module ascii_command_led_controller #(
   parameter int unsigned LINE_DEPTH = aclc_pkg::LINE_DEPTH_DEF,
   localparam int unsigned FILL_W    = $clog2(LINE_DEPTH + 1)
) (
   input  logic          clock,
   input  logic          reset,
   aclc_req_if.sink      req_ch,
   aclc_rsp_if.source    rsp_ch
);

   // Input register
   logic              in_valid_ff, in_valid_in;
   aclc_pkg::req_type in_item_ff,  in_item_in;

   // Result register
   logic              out_valid_ff, out_valid_in;
   aclc_pkg::rsp_type out_item_ff,  out_item_in;

   // Block state
   logic [7:0]        line_ff [aclc_pkg::MATCH_LEN];
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              red_level_ff, red_level_in;
   logic              green_level_ff, green_level_in;
   logic              red_blink_ff, red_blink_in;
   logic              green_blink_ff, green_blink_in;

   logic                line_we;
   aclc_pkg::match_type match;
   logic                req_accept;
   logic                advance;
   logic                is_char;
   logic                is_cr;

   // Item moves from input register to result register when the slot is free
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_accept   = req_ch.valid && req_ch.ready;

   always_comb begin
      in_item_in.mode    = req_ch.mode;
      in_item_in.rx_char = req_ch.rx_char;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   aclc_matcher #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_matcher (
      .line_i  (line_ff),
      .fill_i  (fill_ff),
      .match_o (match)
   );

   assign is_char = (in_item_ff.mode == aclc_pkg::MODE_CHAR) &&
                    (in_item_ff.rx_char != aclc_pkg::CHAR_NUL);
   assign is_cr   = is_char && (in_item_ff.rx_char == aclc_pkg::CHAR_CR);

   // Single-pass decode of the item in the input register
   always_comb begin
      fill_in        = fill_ff;
      red_level_in   = red_level_ff;
      green_level_in = green_level_ff;
      red_blink_in   = red_blink_ff;
      green_blink_in = green_blink_ff;
      line_we        = 1'b0;
      out_item_in    = '0;

      if (in_item_ff.mode == aclc_pkg::MODE_TICK) begin
         red_level_in   = red_level_ff ^ red_blink_ff;
         green_level_in = green_level_ff ^ green_blink_ff;
      end else if (is_char) begin
         out_item_in.echo_valid = 1'b1;
         out_item_in.echo_char  = in_item_ff.rx_char;
         if (is_cr) begin
            out_item_in.command_done = 1'b1;
            fill_in                  = '0;
            case (match.cmd)
               aclc_pkg::CMD_RON:      red_level_in   = 1'b1;
               aclc_pkg::CMD_ROFF:     red_level_in   = 1'b0;
               aclc_pkg::CMD_GON:      green_level_in = 1'b1;
               aclc_pkg::CMD_GOFF:     green_level_in = 1'b0;
               aclc_pkg::CMD_RFLASH:   red_blink_in   = 1'b1;
               aclc_pkg::CMD_GFLASH:   green_blink_in = 1'b1;
               aclc_pkg::CMD_FLASHOFF: begin
                  red_blink_in   = 1'b0;
                  green_blink_in = 1'b0;
               end
               default:                out_item_in.command_invalid = 1'b1;
            endcase
         end else if (in_item_ff.rx_char == aclc_pkg::CHAR_BS) begin
            if (fill_ff != '0) begin
               fill_in = fill_ff - FILL_W'(1);
            end
         end else if (fill_ff < FILL_W'(LINE_DEPTH)) begin
            // only the leading bytes can ever match, so only those are kept
            line_we = (fill_ff < FILL_W'(aclc_pkg::MATCH_LEN));
            fill_in = fill_ff + FILL_W'(1);
         end
      end

      out_item_in.red_led        = red_level_in;
      out_item_in.green_led      = green_level_in;
      out_item_in.red_flashing   = red_blink_in;
      out_item_in.green_flashing = green_blink_in;

      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         fill_ff        <= '0;
         red_level_ff   <= 1'b0;
         green_level_ff <= 1'b0;
         red_blink_ff   <= 1'b0;
         green_blink_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            fill_ff        <= fill_in;
            red_level_ff   <= red_level_in;
            green_level_ff <= green_level_in;
            red_blink_ff   <= red_blink_in;
            green_blink_ff <= green_blink_in;
         end
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= in_item_in;
      end
      if (advance) begin
         out_item_ff <= out_item_in;
      end
      if (advance && line_we) begin
         line_ff[fill_ff[aclc_pkg::MATCH_IDX_W-1:0]] <= in_item_ff.rx_char;
      end
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.echo_valid      = out_item_ff.echo_valid;
   assign rsp_ch.echo_char       = out_item_ff.echo_char;
   assign rsp_ch.red_led         = out_item_ff.red_led;
   assign rsp_ch.green_led       = out_item_ff.green_led;
   assign rsp_ch.red_flashing    = out_item_ff.red_flashing;
   assign rsp_ch.green_flashing  = out_item_ff.green_flashing;
   assign rsp_ch.command_done    = out_item_ff.command_done;
   assign rsp_ch.command_invalid = out_item_ff.command_invalid;

`ifndef SYNTHESIS
   // Line count never passes the buffer depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(LINE_DEPTH))
      else $error("line fill count above depth");

   // A carriage return always leaves an empty line
   a_cr_clears: assert property (@(posedge clock) disable iff (reset)
      advance && is_cr |=> fill_ff == '0)
      else $error("line not cleared after carriage return");

   // Back-pressure only when both the input and result registers are occupied
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> in_valid_ff && out_valid_ff && !rsp_ch.ready)
      else $error("request stalled with a free register");

   // A tick does not disturb a red LED that is not flashing
   a_tick_steady: assert property (@(posedge clock) disable iff (reset)
      advance && in_item_ff.mode == aclc_pkg::MODE_TICK && !red_blink_ff
      |=> $stable(red_level_ff))
      else $error("tick changed a steady red LED");
`endif

endmodule
